// ===== hw/rtl/bqls_pkg.sv =====
// ----------------------------------------------------------------------------
// bqls_pkg
// Shared types and constants of the bracketing quadratic line search.
// ----------------------------------------------------------------------------
package bqls_pkg;

  localparam int WORD_W = 32;
  localparam int CNT_W  = 16;
  localparam int EXT_W  = WORD_W + 2;
  localparam int PROD_W = 4 * WORD_W;
  localparam int HALF_W = 2 * WORD_W;
  localparam int DEN_W  = HALF_W + 2;
  localparam int REM_W  = DEN_W + 1;
  localparam int CIDX_W = 3;

  localparam logic [CIDX_W-1:0] REG_LOWER = 3'd0;
  localparam logic [CIDX_W-1:0] REG_UPPER = 3'd1;
  localparam logic [CIDX_W-1:0] REG_STEP  = 3'd2;
  localparam logic [CIDX_W-1:0] REG_TOL   = 3'd3;
  localparam logic [CIDX_W-1:0] REG_MAXEV = 3'd4;

  localparam logic OP_START = 1'b0;
  localparam logic OP_VALUE = 1'b1;

  localparam logic [1:0] KIND_EVAL   = 2'd0;
  localparam logic [1:0] KIND_DONE   = 2'd1;
  localparam logic [1:0] KIND_REJECT = 2'd2;

  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_FIRST  = 3'd1;
  localparam logic [2:0] PH_LEFT0  = 3'd2;
  localparam logic [2:0] PH_RIGHT0 = 3'd3;
  localparam logic [2:0] PH_MIDV   = 3'd4;
  localparam logic [2:0] PH_LEFTV  = 3'd5;
  localparam logic [2:0] PH_RIGHTV = 3'd6;
  localparam logic [2:0] PH_MAIN   = 3'd7;

  localparam logic [CNT_W-1:0] MIN_EVALS = 16'd5;
  localparam logic [DEN_W-1:0] TAU_DIV   = 66'd10;

  typedef enum logic {AR_MUL, AR_DIV} arith_op_e;

  typedef struct packed {
    logic      start;
    arith_op_e op;
  } arith_ctl_t;

  typedef struct packed {
    logic done;
    logic ovf;
  } arith_sts_t;

endpackage

// ===== hw/rtl/bqls_arith.sv =====
// ----------------------------------------------------------------------------
// bqls_arith
// Bit-serial shift-add multiplier and restoring divider, one bit per cycle.
// ----------------------------------------------------------------------------
module bqls_arith import bqls_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  arith_ctl_t        ctl_i,
  input  logic [PROD_W-1:0] opa_i,
  input  logic [DEN_W-1:0]  opb_i,
  output arith_sts_t        sts_o,
  output logic [PROD_W-1:0] res_o
);

  localparam int IDX_W = $clog2(PROD_W);
  localparam logic [IDX_W-1:0] MUL_LAST = IDX_W'(WORD_W - 1);
  localparam logic [IDX_W-1:0] DIV_LAST = IDX_W'(PROD_W - 1);
  localparam logic [IDX_W-1:0] OVF_END  = IDX_W'(PROD_W - WORD_W);

  logic              busy_q;
  arith_op_e         op_q;
  logic [IDX_W-1:0]  idx_q;
  logic [PROD_W-1:0] acc_q;
  logic [PROD_W-1:0] src_q;
  logic [WORD_W-1:0] mp_q;
  logic [DEN_W-1:0]  den_q;
  logic [REM_W-1:0]  rem_q;
  logic              ovf_q;
  logic              done_q;

  logic [REM_W-1:0]  rem_sh;
  logic [REM_W-1:0]  rem_sub;
  logic              rem_ge;
  logic              last;

  always_comb begin
    rem_sh  = {rem_q[REM_W-2:0], src_q[PROD_W-1]};
    rem_ge  = rem_sh >= {1'b0, den_q};
    rem_sub = rem_sh - {1'b0, den_q};
    last    = (op_q == AR_MUL) ? (idx_q == MUL_LAST) : (idx_q == DIV_LAST);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      op_q   <= AR_MUL;
      idx_q  <= '0;
      acc_q  <= '0;
      src_q  <= '0;
      mp_q   <= '0;
      den_q  <= '0;
      rem_q  <= '0;
      ovf_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (ctl_i.start) begin
        busy_q <= 1'b1;
        op_q   <= ctl_i.op;
        idx_q  <= '0;
        acc_q  <= '0;
        rem_q  <= '0;
        ovf_q  <= 1'b0;
        src_q  <= opa_i;
        mp_q   <= opb_i[WORD_W-1:0];
        den_q  <= opb_i;
      end else if (busy_q) begin
        idx_q <= idx_q + 1'b1;
        src_q <= {src_q[PROD_W-2:0], 1'b0};
        if (op_q == AR_MUL) begin
          if (mp_q[0]) begin
            acc_q <= acc_q + src_q;
          end
          mp_q <= {1'b0, mp_q[WORD_W-1:1]};
        end else begin
          rem_q <= rem_ge ? rem_sub : rem_sh;
          acc_q <= {acc_q[PROD_W-2:0], rem_ge};
          if (rem_ge && idx_q < OVF_END) begin
            ovf_q <= 1'b1;
          end
        end
        if (last) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign sts_o.done = done_q;
  assign sts_o.ovf  = ovf_q;
  assign res_o      = acc_q;

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q) else $error("arith done held");
  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.start |-> !busy_q) else $error("arith started while busy");
  a_mul_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && op_q == AR_MUL) |-> idx_q <= MUL_LAST) else $error("multiply overran");

endmodule

// ===== hw/rtl/bracketing_quadratic_line_search.sv =====
// ----------------------------------------------------------------------------
// bracketing_quadratic_line_search
// One-dimensional minimizer over signed Q16.16, driven by an outside evaluator.
// ----------------------------------------------------------------------------
// input transactions: tuser[0] selects start (0) or value (1); tdata carries
// start_point and func_value. each accepted transaction gives at most one
// output transaction: kind in tuser, point / value / evals_used in tdata.
// a start checks the limits and registers and answers with the first point
// or a reject; each value answers with the next point to evaluate or with
// the final point and value. a value while no run is active is dropped.
// an interpolation step runs four serial multiplies and up to two serial
// divides in the shared arith unit, one after the other.
// one transaction is worked on at a time; the input is ready only between
// transactions. the result sits in an output register, so a stalled
// receiver holds back only the next result, not the next input.
// reset sets the control and config registers to defaults; the block is idle.
// config writes are taken any cycle and must come while the block is idle.
// ----------------------------------------------------------------------------
module bracketing_quadratic_line_search import bqls_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_wr_en_i,
  input  logic [CIDX_W-1:0] cfg_idx_i,
  input  logic [WORD_W-1:0] cfg_data_i,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [63:0]       s_axis_tdata,   // start_point, func_value
  input  logic [0:0]        s_axis_tuser,   // operation
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [79:0]       m_axis_tdata,   // point, value, evals_used
  output logic [1:0]        m_axis_tuser    // kind
);

  localparam logic [3:0] ST_ACCEPT = 4'd0;
  localparam logic [3:0] ST_BRK    = 4'd1;
  localparam logic [3:0] ST_MAIN   = 4'd2;
  localparam logic [3:0] ST_MUL_A  = 4'd3;
  localparam logic [3:0] ST_MUL_B  = 4'd4;
  localparam logic [3:0] ST_MUL_X  = 4'd5;
  localparam logic [3:0] ST_MUL_Y  = 4'd6;
  localparam logic [3:0] ST_DIVQ   = 4'd7;
  localparam logic [3:0] ST_SIDE   = 4'd8;
  localparam logic [3:0] ST_DIV10  = 4'd9;
  localparam logic [3:0] ST_GUARD  = 4'd10;
  localparam logic [3:0] ST_RATIO  = 4'd11;
  localparam logic [3:0] ST_EMIT   = 4'd12;

  function automatic logic signed [EXT_W-1:0] sx(input logic [WORD_W-1:0] v);
    sx = $signed({{2{v[WORD_W-1]}}, v});
  endfunction

  function automatic logic signed [EXT_W-1:0] zx(input logic [WORD_W-1:0] v);
    zx = $signed({2'b00, v});
  endfunction

  function automatic logic [WORD_W-1:0] half(input logic [WORD_W-1:0] a,
                                             input logic [WORD_W-1:0] b);
    logic signed [EXT_W-1:0] s;
    s = sx(a) + sx(b);
    half = s[WORD_W:1];
  endfunction

  function automatic logic [EXT_W-1:0] absx(input logic signed [EXT_W-1:0] v);
    absx = v[EXT_W-1] ? EXT_W'(-v) : EXT_W'(v);
  endfunction

  function automatic logic [WORD_W+6:0] x100(input logic [WORD_W-1:0] v);
    x100 = {1'b0, v, 6'b0} + {2'b0, v, 5'b0} + {5'b0, v, 2'b0};
  endfunction

  // configuration
  logic signed [WORD_W-1:0] lower_q, upper_q;
  logic [WORD_W-2:0]        step_q, tol_q;
  logic [CNT_W-1:0]         maxev_q;

  // search state
  logic [3:0]               state_q, state_d;
  logic [2:0]               phase_q, phase_d;
  logic signed [WORD_W-1:0] p1_q, p2_q, p3_q, p1_d, p2_d, p3_d;
  logic signed [WORD_W-1:0] f1_q, f2_q, f3_q, f1_d, f2_d, f3_d;
  logic signed [WORD_W-1:0] pend_q, pend_d, pm_q, pm_d;
  logic [WORD_W-1:0]        jump_q, jump_d, g_q, g_d;
  logic [CNT_W-1:0]         cnt_q, cnt_d, cnt_base;
  logic [HALF_W-1:0]        a_q, a_d, b_q, b_d;
  logic [PROD_W-1:0]        x_q, x_d;
  logic                     neg_q, neg_d;
  logic [1:0]               kind_q, kind_d;
  logic [WORD_W-1:0]        rpt_q, rpt_d, rval_q, rval_d;

  // output register
  logic                     mv_q;
  logic [1:0]               mkind_q;
  logic [WORD_W-1:0]        mpoint_q, mvalue_q;
  logic [CNT_W-1:0]         mevals_q;

  // arith unit
  arith_ctl_t               ar_ctl;
  arith_sts_t               ar_sts;
  logic [PROD_W-1:0]        ar_opa, ar_res;
  logic [DEN_W-1:0]         ar_opb;

  // datapath
  logic                     s_op;
  logic signed [WORD_W-1:0] s_pt, s_fv;
  logic signed [EXT_W-1:0]  d21, d32, d31, g1, g3, span, tol_x;
  logic signed [EXT_W-1:0]  first_lo, first_hi, brk_lo, brk_hi;
  logic [WORD_W-1:0]        u, w, first_lo_pt, first_hi_pt, brk_lo_pt, brk_hi_pt;
  logic [WORD_W-1:0]        jump_dbl;
  logic                     reject, main_fin, emit_go;
  logic [DEN_W-1:0]         den;
  logic                     neg;
  logic [PROD_W-1:0]        mag;
  logic signed [EXT_W-1:0]  dq;
  logic [WORD_W-1:0]        divq_pt, guard_pt, ratio_pt;
  logic signed [EXT_W-1:0]  pm_x, gx;
  logic [EXT_W-1:0]         e1, e2;
  logic                     ratio_ok;

  logic                     do_req, do_fin;
  logic [2:0]               req_ph;
  logic [WORD_W-1:0]        req_pt, fin_pt, fin_val;

  bqls_arith u_arith (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ar_ctl),
    .opa_i  (ar_opa),
    .opb_i  (ar_opb),
    .sts_o  (ar_sts),
    .res_o  (ar_res)
  );

  assign s_op = s_axis_tuser[0];
  assign s_pt = s_axis_tdata[WORD_W-1:0];
  assign s_fv = s_axis_tdata[2*WORD_W-1:WORD_W];

  always_comb begin
    d21   = sx(p2_q) - sx(p1_q);
    d32   = sx(p3_q) - sx(p2_q);
    d31   = sx(p3_q) - sx(p1_q);
    u     = d21[WORD_W-1:0];
    w     = d32[WORD_W-1:0];
    g1    = sx(f1_q) - sx(f2_q);
    g3    = sx(f3_q) - sx(f2_q);
    span  = sx(upper_q) - sx(lower_q);
    tol_x = $signed({3'b000, tol_q});

    first_lo    = sx(p2_q) - $signed({3'b000, step_q});
    first_hi    = sx(p2_q) + $signed({3'b000, step_q});
    first_lo_pt = (first_lo < sx(lower_q)) ? lower_q : first_lo[WORD_W-1:0];
    first_hi_pt = (first_hi > sx(upper_q)) ? upper_q : first_hi[WORD_W-1:0];
    brk_lo      = sx(p1_q) - zx(jump_q);
    brk_hi      = sx(p3_q) + zx(jump_q);
    brk_lo_pt   = (brk_lo < sx(lower_q)) ? lower_q : brk_lo[WORD_W-1:0];
    brk_hi_pt   = (brk_hi > sx(upper_q)) ? upper_q : brk_hi[WORD_W-1:0];
    jump_dbl    = jump_q[WORD_W-1] ? '1 : {jump_q[WORD_W-2:0], 1'b0};

    reject = (lower_q > upper_q) || (s_pt < lower_q) || (s_pt > upper_q) ||
             (step_q == '0) || (tol_q == '0) || (tol_q >= step_q) ||
             (maxev_q < MIN_EVALS);
    main_fin = !((cnt_q < maxev_q) && (d31 > tol_x));

    den = {({1'b0, a_q} + {1'b0, b_q}), 1'b0};
    neg = x_q < ar_res;
    mag = neg ? (ar_res - x_q) : (x_q - ar_res);

    dq = neg_q ? (sx(p2_q) - zx(ar_res[WORD_W-1:0]))
               : (sx(p2_q) + zx(ar_res[WORD_W-1:0]));
    if (ar_sts.ovf) begin
      divq_pt = p2_q;
    end else if (dq < sx(p1_q)) begin
      divq_pt = p1_q;
    end else if (dq > sx(p3_q)) begin
      divq_pt = p3_q;
    end else begin
      divq_pt = dq[WORD_W-1:0];
    end

    pm_x = sx(pm_q);
    gx   = zx(g_q);
    guard_pt = pm_q;
    if (pm_q < p2_q) begin
      e1 = absx(pm_x - sx(p1_q));
      e2 = absx(sx(p2_q) - pm_x);
      if (e1 < EXT_W'(gx)) begin
        guard_pt = WORD_W'(sx(p1_q) + gx);
      end else if (e2 < EXT_W'(gx)) begin
        guard_pt = WORD_W'(sx(p2_q) - gx);
      end
    end else begin
      e1 = absx(pm_x - sx(p2_q));
      e2 = absx(sx(p3_q) - pm_x);
      if (e1 < EXT_W'(gx)) begin
        guard_pt = WORD_W'(sx(p2_q) + gx);
      end else if (e2 < EXT_W'(gx)) begin
        guard_pt = WORD_W'(sx(p3_q) - gx);
      end
    end

    ratio_ok = ({7'b0, u} < x100(w)) && (x100(u) > {7'b0, w});
    ratio_pt = pm_q;
    if (!ratio_ok) begin
      if (u > w && pm_q > p2_q) begin
        ratio_pt = half(p1_q, p2_q);
      end else if (pm_q < p2_q) begin
        ratio_pt = half(p2_q, p3_q);
      end
    end
  end

  always_comb begin
    state_d  = state_q;
    phase_d  = phase_q;
    p1_d     = p1_q;
    p2_d     = p2_q;
    p3_d     = p3_q;
    f1_d     = f1_q;
    f2_d     = f2_q;
    f3_d     = f3_q;
    pend_d   = pend_q;
    jump_d   = jump_q;
    cnt_d    = cnt_q;
    cnt_base = cnt_q;
    a_d      = a_q;
    b_d      = b_q;
    x_d      = x_q;
    neg_d    = neg_q;
    pm_d     = pm_q;
    g_d      = g_q;
    kind_d   = kind_q;
    rpt_d    = rpt_q;
    rval_d   = rval_q;
    ar_ctl   = '{start: 1'b0, op: AR_MUL};
    ar_opa   = '0;
    ar_opb   = '0;
    do_req   = 1'b0;
    req_ph   = phase_q;
    req_pt   = pm_q;
    do_fin   = 1'b0;
    fin_pt   = p2_q;
    fin_val  = f2_q;
    emit_go  = !mv_q || m_axis_tready;

    case (state_q)
      ST_ACCEPT: begin
        if (s_axis_tvalid) begin
          if (s_op == OP_START) begin
            cnt_base = '0;
            cnt_d    = '0;
            if (reject) begin
              phase_d = PH_IDLE;
              kind_d  = KIND_REJECT;
              rpt_d   = '0;
              rval_d  = '0;
              state_d = ST_EMIT;
            end else begin
              p2_d   = s_pt;
              jump_d = {1'b0, step_q};
              do_req = 1'b1;
              req_ph = PH_FIRST;
              req_pt = s_pt;
            end
          end else begin
            case (phase_q)
              PH_FIRST: begin
                f2_d = s_fv;
                if (lower_q >= upper_q) begin
                  do_fin  = 1'b1;
                  fin_val = s_fv;
                end else begin
                  p1_d   = first_lo_pt;
                  p3_d   = first_hi_pt;
                  do_req = 1'b1;
                  req_ph = PH_LEFT0;
                  req_pt = first_lo_pt;
                end
              end
              PH_LEFT0: begin
                f1_d   = s_fv;
                do_req = 1'b1;
                req_ph = PH_RIGHT0;
                req_pt = p3_q;
              end
              PH_RIGHT0: begin
                f3_d = s_fv;
                if (p2_q == p1_q || p2_q == p3_q) begin
                  p2_d   = half(p1_q, p3_q);
                  do_req = 1'b1;
                  req_ph = PH_MIDV;
                  req_pt = half(p1_q, p3_q);
                end else begin
                  state_d = ST_BRK;
                end
              end
              PH_MIDV: begin
                f2_d    = s_fv;
                state_d = ST_BRK;
              end
              PH_LEFTV: begin
                f1_d    = s_fv;
                state_d = ST_BRK;
              end
              PH_RIGHTV: begin
                f3_d    = s_fv;
                state_d = ST_BRK;
              end
              PH_MAIN: begin
                if (pend_q < p2_q) begin
                  if (f1_q > s_fv && s_fv < f2_q) begin
                    p3_d = p2_q;
                    f3_d = f2_q;
                    p2_d = pend_q;
                    f2_d = s_fv;
                  end else begin
                    p1_d = pend_q;
                    f1_d = s_fv;
                  end
                end else begin
                  if (f2_q > s_fv && s_fv < f3_q) begin
                    p1_d = p2_q;
                    f1_d = f2_q;
                    p2_d = pend_q;
                    f2_d = s_fv;
                  end else begin
                    p3_d = pend_q;
                    f3_d = s_fv;
                  end
                end
                state_d = ST_MAIN;
              end
              default: begin
              end
            endcase
          end
        end
      end
      ST_BRK: begin
        if (f1_q > f2_q && f2_q < f3_q) begin
          state_d = ST_MAIN;
        end else if (cnt_q >= maxev_q) begin
          do_fin = 1'b1;
        end else if (d31 < tol_x) begin
          do_fin = 1'b1;
          if (f1_q < f2_q && f1_q < f3_q) begin
            fin_pt  = p1_q;
            fin_val = f1_q;
          end else if (f2_q < f1_q && f2_q < f3_q) begin
            fin_pt  = p2_q;
            fin_val = f2_q;
          end else begin
            fin_pt  = p3_q;
            fin_val = f3_q;
          end
        end else if (f1_q < f3_q) begin
          p3_d   = p2_q;
          f3_d   = f2_q;
          do_req = 1'b1;
          if (p1_q == lower_q || (f1_q == f2_q && span[WORD_W-1:0] < jump_q)) begin
            p2_d   = half(p1_q, p2_q);
            req_ph = PH_MIDV;
            req_pt = half(p1_q, p2_q);
          end else begin
            p2_d   = p1_q;
            f2_d   = f1_q;
            p1_d   = brk_lo_pt;
            jump_d = jump_dbl;
            req_ph = PH_LEFTV;
            req_pt = brk_lo_pt;
          end
        end else begin
          p1_d   = p2_q;
          f1_d   = f2_q;
          do_req = 1'b1;
          if (p3_q == upper_q || (f2_q == f3_q && span[WORD_W-1:0] < jump_q)) begin
            p2_d   = half(p3_q, p2_q);
            req_ph = PH_MIDV;
            req_pt = half(p3_q, p2_q);
          end else begin
            p2_d   = p3_q;
            f2_d   = f3_q;
            p3_d   = brk_hi_pt;
            jump_d = jump_dbl;
            req_ph = PH_RIGHTV;
            req_pt = brk_hi_pt;
          end
        end
      end
      ST_MAIN: begin
        if (main_fin) begin
          do_fin = 1'b1;
        end else begin
          ar_ctl  = '{start: 1'b1, op: AR_MUL};
          ar_opa  = {{(PROD_W-EXT_W){g1[EXT_W-1]}}, g1};
          ar_opb  = DEN_W'(w);
          state_d = ST_MUL_A;
        end
      end
      ST_MUL_A: begin
        if (ar_sts.done) begin
          a_d     = ar_res[HALF_W-1:0];
          ar_ctl  = '{start: 1'b1, op: AR_MUL};
          ar_opa  = {{(PROD_W-EXT_W){g3[EXT_W-1]}}, g3};
          ar_opb  = DEN_W'(u);
          state_d = ST_MUL_B;
        end
      end
      ST_MUL_B: begin
        if (ar_sts.done) begin
          b_d     = ar_res[HALF_W-1:0];
          ar_ctl  = '{start: 1'b1, op: AR_MUL};
          ar_opa  = PROD_W'(a_q);
          ar_opb  = DEN_W'(w);
          state_d = ST_MUL_X;
        end
      end
      ST_MUL_X: begin
        if (ar_sts.done) begin
          x_d     = ar_res;
          ar_ctl  = '{start: 1'b1, op: AR_MUL};
          ar_opa  = PROD_W'(b_q);
          ar_opb  = DEN_W'(u);
          state_d = ST_MUL_Y;
        end
      end
      ST_MUL_Y: begin
        if (ar_sts.done) begin
          if (den == '0) begin
            pm_d    = p2_q;
            state_d = ST_SIDE;
          end else begin
            neg_d   = neg;
            ar_ctl  = '{start: 1'b1, op: AR_DIV};
            ar_opa  = mag;
            ar_opb  = den;
            state_d = ST_DIVQ;
          end
        end
      end
      ST_DIVQ: begin
        if (ar_sts.done) begin
          pm_d    = divq_pt;
          state_d = ST_SIDE;
        end
      end
      ST_SIDE: begin
        ar_ctl  = '{start: 1'b1, op: AR_DIV};
        ar_opa  = (pm_q < p2_q) ? PROD_W'(u) : PROD_W'(w);
        ar_opb  = TAU_DIV;
        state_d = ST_DIV10;
      end
      ST_DIV10: begin
        if (ar_sts.done) begin
          g_d     = ar_res[WORD_W-1:0];
          state_d = ST_GUARD;
        end
      end
      ST_GUARD: begin
        pm_d    = guard_pt;
        state_d = ST_RATIO;
      end
      ST_RATIO: begin
        do_req = 1'b1;
        req_ph = PH_MAIN;
        req_pt = ratio_pt;
      end
      ST_EMIT: begin
        if (emit_go) begin
          state_d = ST_ACCEPT;
        end
      end
      default: begin
        state_d = ST_ACCEPT;
      end
    endcase

    if (do_req) begin
      phase_d = req_ph;
      pend_d  = req_pt;
      cnt_d   = cnt_base + 1'b1;
      kind_d  = KIND_EVAL;
      rpt_d   = req_pt;
      rval_d  = '0;
      state_d = ST_EMIT;
    end
    if (do_fin) begin
      phase_d = PH_IDLE;
      kind_d  = KIND_DONE;
      rpt_d   = fin_pt;
      rval_d  = fin_val;
      state_d = ST_EMIT;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lower_q <= '0;
      upper_q <= 32'sd65536;
      step_q  <= 31'd6554;
      tol_q   <= 31'd66;
      maxev_q <= 16'd100;
    end else if (cfg_wr_en_i) begin
      case (cfg_idx_i)
        REG_LOWER: lower_q <= cfg_data_i;
        REG_UPPER: upper_q <= cfg_data_i;
        REG_STEP:  step_q  <= cfg_data_i[WORD_W-2:0];
        REG_TOL:   tol_q   <= cfg_data_i[WORD_W-2:0];
        REG_MAXEV: maxev_q <= cfg_data_i[CNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_ACCEPT;
      phase_q <= PH_IDLE;
      p1_q    <= '0;
      p2_q    <= '0;
      p3_q    <= '0;
      f1_q    <= '0;
      f2_q    <= '0;
      f3_q    <= '0;
      pend_q  <= '0;
      jump_q  <= '0;
      cnt_q   <= '0;
      mv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      p1_q    <= p1_d;
      p2_q    <= p2_d;
      p3_q    <= p3_d;
      f1_q    <= f1_d;
      f2_q    <= f2_d;
      f3_q    <= f3_d;
      pend_q  <= pend_d;
      jump_q  <= jump_d;
      cnt_q   <= cnt_d;
      if (state_q == ST_EMIT && emit_go) begin
        mv_q <= 1'b1;
      end else if (m_axis_tready) begin
        mv_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    a_q    <= a_d;
    b_q    <= b_d;
    x_q    <= x_d;
    neg_q  <= neg_d;
    pm_q   <= pm_d;
    g_q    <= g_d;
    kind_q <= kind_d;
    rpt_q  <= rpt_d;
    rval_q <= rval_d;
    if (state_q == ST_EMIT && emit_go) begin
      mkind_q  <= kind_q;
      mpoint_q <= rpt_q;
      mvalue_q <= rval_q;
      mevals_q <= cnt_q;
    end
  end

  assign s_axis_tready = (state_q == ST_ACCEPT);
  assign m_axis_tvalid = mv_q;
  assign m_axis_tdata  = {mevals_q, mvalue_q, mpoint_q};
  assign m_axis_tuser  = mkind_q;

  a_emit_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT && emit_go) |=> (mv_q && state_q == ST_ACCEPT))
    else $error("result not loaded");
  a_idle_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && s_op == OP_VALUE && phase_q == PH_IDLE)
    |=> state_q == ST_ACCEPT) else $error("idle value not dropped");
  a_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_MAIN && state_q == ST_ACCEPT) |-> (p1_q <= p2_q && p2_q <= p3_q))
    else $error("bracket out of order");

endmodule
